[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, register indexes, constants and types for the pressure and
// temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RawW    = 24;
    localparam int CoefW   = 16;
    localparam int DtW     = RawW + 1;
    localparam int TempW   = 20;
    localparam int PressW  = 25;
    localparam int WideW   = 40;
    localparam int ProdW   = 64;
    localparam int DataW   = 32;
    localparam int AddrW   = 5;
    localparam int RegIdxW = 3;

    localparam int ProdTW  = DtW + CoefW + 1;
    localparam int ProdDdW = 2 * DtW;
    localparam int SqW     = 2 * TempW;
    localparam int SplitW  = 20;
    localparam int HiW     = WideW - SplitW;
    localparam int PloW    = RawW + SplitW;
    localparam int PhiW    = RawW + 1 + HiW;

    localparam int C5Sh    = 8;
    localparam int ShT     = 23;
    localparam int ShOff   = 7;
    localparam int ShSens  = 8;
    localparam int ShT2    = 31;
    localparam int ShOffC  = 16;
    localparam int ShSensC = 15;
    localparam int ShP1    = 21;
    localparam int ShP2    = 15;

    localparam logic signed [TempW-1:0] TEMP_REF = 20'sd2000;
    localparam logic signed [TempW-1:0] TEMP_LOW = -20'sd1500;

    localparam logic [RegIdxW-1:0] REG_C1 = 3'd0;
    localparam logic [RegIdxW-1:0] REG_C2 = 3'd1;
    localparam logic [RegIdxW-1:0] REG_C3 = 3'd2;
    localparam logic [RegIdxW-1:0] REG_C4 = 3'd3;
    localparam logic [RegIdxW-1:0] REG_C5 = 3'd4;
    localparam logic [RegIdxW-1:0] REG_C6 = 3'd5;

    typedef struct packed {
        logic [CoefW-1:0] c1;
        logic [CoefW-1:0] c2;
        logic [CoefW-1:0] c3;
        logic [CoefW-1:0] c4;
        logic [CoefW-1:0] c5;
        logic [CoefW-1:0] c6;
    } cal_t;

    typedef struct packed {
        logic signed [TempW-1:0] temp;
        logic signed [WideW-1:0] off;
        logic signed [WideW-1:0] sens;
        logic [RawW-1:0]         d1;
    } comp_t;

endpackage

[rtl/ptc_ifs.sv]
// ----------------------------------------------------------------------------
// ptc_ifs
// Valid/ready channels for raw sample beats and compensated result beats.
// ----------------------------------------------------------------------------
interface ptc_in_if;
    import ptc_pkg::*;

    logic            valid;
    logic            ready;
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_out_if;
    import ptc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TempW-1:0] temperature_centi;
    logic [PressW-1:0]       pressure_pascal;

    modport source (output valid, output temperature_centi, output pressure_pascal, input ready);
    modport sink (input valid, input temperature_centi, input pressure_pascal, output ready);
endinterface

[rtl/pressure_temperature_compensation_top.sv]
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Second-order compensation of raw barometric sensor conversions.
// ----------------------------------------------------------------------------
// Takes one raw pressure/temperature beat per clock while the output is not
// stalled and returns one result beat per input beat, in order. Throughput is
// one beat per cycle while the output is not stalled; the depth is set by the
// multiplier stages (calibration products, the squared temperature terms and
// the 64-bit pressure product split in two halves). A stall on the output
// holds only the occupied stages, empty stages still take new beats. The six
// calibration words sit at APB byte addresses 0x00 to 0x14 and must be written
// while no beat is in flight.
module pressure_temperature_compensation_top (
    input  logic                       clk,
    input  logic                       rst_n,
    ptc_in_if.sink                     sample_in,
    ptc_out_if.source                  result_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptc_pkg::AddrW-1:0]  paddr,
    input  logic [ptc_pkg::DataW-1:0]  pwdata,
    output logic [ptc_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import ptc_pkg::*;

    cal_t  cal;
    comp_t mid;
    logic  mid_valid;
    logic  mid_ready;

    ptc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    ptc_comp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .sample_in (sample_in),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    ptc_press_calc u_press (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_valid  (mid_valid),
        .mid_ready  (mid_ready),
        .mid        (mid),
        .result_out (result_out)
    );

    // input held off only by a blocked output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_in.ready |-> result_out.valid && !result_out.ready)
        else $error("input stalled without output backpressure");

    // compensated temperature stays in its physical range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> result_out.temperature_centi >= -20'sd270000
                          && result_out.temperature_centi <= 20'sd140000)
        else $error("temperature out of range");

    // middle hand-off never stalls while the output side is free
    a_mid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.ready |-> mid_ready)
        else $error("pipeline stalled with free output");

endmodule

[rtl/ptc_apb_regs.sv]
// ----------------------------------------------------------------------------
// ptc_apb_regs
// APB register file holding the six calibration words.
// ----------------------------------------------------------------------------
module ptc_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptc_pkg::AddrW-1:0]  paddr,
    input  logic [ptc_pkg::DataW-1:0]  pwdata,
    output logic [ptc_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output ptc_pkg::cal_t              cal
);
    import ptc_pkg::*;

    cal_t               cal_reg;
    cal_t               cal_next;
    logic [RegIdxW-1:0] idx;
    logic               wr_en;

    assign idx    = paddr[AddrW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        if (wr_en)
        begin
            case (idx)
                REG_C1:  cal_next.c1 = pwdata[CoefW-1:0];
                REG_C2:  cal_next.c2 = pwdata[CoefW-1:0];
                REG_C3:  cal_next.c3 = pwdata[CoefW-1:0];
                REG_C4:  cal_next.c4 = pwdata[CoefW-1:0];
                REG_C5:  cal_next.c5 = pwdata[CoefW-1:0];
                REG_C6:  cal_next.c6 = pwdata[CoefW-1:0];
                default: cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_C1:  prdata = DataW'(cal_reg.c1);
            REG_C2:  prdata = DataW'(cal_reg.c2);
            REG_C3:  prdata = DataW'(cal_reg.c3);
            REG_C4:  prdata = DataW'(cal_reg.c4);
            REG_C5:  prdata = DataW'(cal_reg.c5);
            REG_C6:  prdata = DataW'(cal_reg.c6);
            default: prdata = '0;
        endcase
    end

endmodule

[rtl/ptc_comp_core.sv]
// ----------------------------------------------------------------------------
// ptc_comp_core
// Six-stage pipeline: temperature difference, first-order terms and the
// second-order corrections to temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module ptc_comp_core (
    input  logic           clk,
    input  logic           rst_n,
    input  ptc_pkg::cal_t  cal,
    ptc_in_if.sink         sample_in,
    output logic           mid_valid,
    input  logic           mid_ready,
    output ptc_pkg::comp_t mid
);
    import ptc_pkg::*;

    localparam int NumSt = 6;

    logic [NumSt-1:0] vld_reg;
    logic [NumSt-1:0] vld_next;
    logic [NumSt-1:0] vld_src;
    logic [NumSt:0]   adv;

    // stage 1
    logic [RawW-1:0]         d1_s1_reg;
    logic signed [DtW-1:0]   dt_s1_reg;
    logic signed [DtW-1:0]   dt_next;
    // stage 2
    logic [RawW-1:0]           d1_s2_reg;
    logic signed [ProdTW-1:0]  pt_s2_reg;
    logic signed [ProdTW-1:0]  po_s2_reg;
    logic signed [ProdTW-1:0]  ps_s2_reg;
    logic signed [ProdDdW-1:0] pdd_s2_reg;
    // stage 3
    logic [RawW-1:0]         d1_s3_reg;
    logic signed [TempW-1:0] temp1_s3_reg;
    logic signed [TempW-1:0] t2_s3_reg;
    logic signed [WideW-1:0] off1_s3_reg;
    logic signed [WideW-1:0] sens1_s3_reg;
    logic signed [TempW-1:0] temp1_next;
    logic signed [TempW-1:0] t2_next;
    logic signed [WideW-1:0] off1_next;
    logic signed [WideW-1:0] sens1_next;
    // stage 4
    logic [RawW-1:0]         d1_s4_reg;
    logic signed [TempW-1:0] temp1_s4_reg;
    logic signed [TempW-1:0] t2_s4_reg;
    logic signed [WideW-1:0] off1_s4_reg;
    logic signed [WideW-1:0] sens1_s4_reg;
    logic signed [SqW-1:0]   uu_s4_reg;
    logic signed [SqW-1:0]   vv_s4_reg;
    logic                    low_s4_reg;
    logic                    vlow_s4_reg;
    logic signed [TempW-1:0] u_val;
    logic signed [TempW-1:0] v_val;
    // stage 5
    logic [RawW-1:0]         d1_s5_reg;
    logic signed [TempW-1:0] temp_s5_reg;
    logic signed [WideW-1:0] off1_s5_reg;
    logic signed [WideW-1:0] sens1_s5_reg;
    logic signed [WideW-1:0] off2_s5_reg;
    logic signed [WideW-1:0] sens2_s5_reg;
    logic signed [SqW-1:0]   uu5;
    logic signed [SqW-1:0]   vv7;
    logic signed [SqW-1:0]   vv11;
    logic signed [WideW-1:0] off2_next;
    logic signed [WideW-1:0] sens2_next;
    logic signed [TempW-1:0] temp_next;
    // stage 6
    comp_t mid_reg;

    assign vld_src = {vld_reg[NumSt-2:0], sample_in.valid};

    always_comb
    begin
        adv[NumSt] = mid_ready;
        for (int k = NumSt - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NumSt; k++)
        begin
            vld_next[k] = adv[k] ? vld_src[k] : vld_reg[k];
        end
    end

    assign sample_in.ready = adv[0];
    assign mid_valid       = vld_reg[NumSt-1];
    assign mid             = mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // temperature difference
    assign dt_next = $signed({1'b0, sample_in.raw_temperature})
                   - $signed({1'b0, cal.c5, {C5Sh{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_s1_reg <= sample_in.raw_pressure;
            dt_s1_reg <= dt_next;
        end
    end

    // products with the calibration words and the square of the temperature difference
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            d1_s2_reg  <= d1_s1_reg;
            pt_s2_reg  <= dt_s1_reg * $signed({1'b0, cal.c6});
            po_s2_reg  <= dt_s1_reg * $signed({1'b0, cal.c4});
            ps_s2_reg  <= dt_s1_reg * $signed({1'b0, cal.c3});
            pdd_s2_reg <= dt_s1_reg * dt_s1_reg;
        end
    end

    // first-order terms and the second-order temperature term T2
    always_comb
    begin
        temp1_next = TEMP_REF + TempW'(pt_s2_reg >>> ShT);
        t2_next    = TempW'(pdd_s2_reg >>> ShT2);
        off1_next  = $signed(WideW'({cal.c2, {ShOffC{1'b0}}}))
                   + WideW'(po_s2_reg >>> ShOff);
        sens1_next = $signed(WideW'({cal.c1, {ShSensC{1'b0}}}))
                   + WideW'(ps_s2_reg >>> ShSens);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            d1_s3_reg    <= d1_s2_reg;
            temp1_s3_reg <= temp1_next;
            t2_s3_reg    <= t2_next;
            off1_s3_reg  <= off1_next;
            sens1_s3_reg <= sens1_next;
        end
    end

    // squares of the distance below the thresholds
    assign u_val = temp1_s3_reg - TEMP_REF;
    assign v_val = temp1_s3_reg - TEMP_LOW;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            d1_s4_reg    <= d1_s3_reg;
            temp1_s4_reg <= temp1_s3_reg;
            t2_s4_reg    <= t2_s3_reg;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            uu_s4_reg    <= u_val * u_val;
            vv_s4_reg    <= v_val * v_val;
            low_s4_reg   <= temp1_s3_reg < TEMP_REF;
            vlow_s4_reg  <= temp1_s3_reg < TEMP_LOW;
        end
    end

    // second-order corrections
    always_comb
    begin
        uu5  = (uu_s4_reg <<< 2) + uu_s4_reg;
        vv7  = (vv_s4_reg <<< 3) - vv_s4_reg;
        vv11 = (vv_s4_reg <<< 3) + (vv_s4_reg <<< 1) + vv_s4_reg;
        off2_next  = '0;
        sens2_next = '0;
        temp_next  = temp1_s4_reg;
        if (low_s4_reg)
        begin
            temp_next  = temp1_s4_reg - t2_s4_reg;
            off2_next  = WideW'(uu5 >>> 1);
            sens2_next = WideW'(uu5 >>> 2);
            if (vlow_s4_reg)
            begin
                off2_next  = WideW'(uu5 >>> 1) + WideW'(vv7);
                sens2_next = WideW'(uu5 >>> 2) + WideW'(vv11 >>> 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            d1_s5_reg    <= d1_s4_reg;
            temp_s5_reg  <= temp_next;
            off1_s5_reg  <= off1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            off2_s5_reg  <= off2_next;
            sens2_s5_reg <= sens2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            mid_reg.d1   <= d1_s5_reg;
            mid_reg.temp <= temp_s5_reg;
            mid_reg.off  <= off1_s5_reg - off2_s5_reg;
            mid_reg.sens <= sens1_s5_reg - sens2_s5_reg;
        end
    end

endmodule

[rtl/ptc_press_calc.sv]
// ----------------------------------------------------------------------------
// ptc_press_calc
// Three-stage pipeline: split raw pressure by sensitivity product, offset
// removal, scaling and clamp to zero.
// ----------------------------------------------------------------------------
module ptc_press_calc (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mid_valid,
    output logic           mid_ready,
    input  ptc_pkg::comp_t mid,
    ptc_out_if.source      result_out
);
    import ptc_pkg::*;

    localparam int NumSt = 3;

    logic [NumSt-1:0] vld_reg;
    logic [NumSt-1:0] vld_next;
    logic [NumSt-1:0] vld_src;
    logic [NumSt:0]   adv;

    // stage 1
    logic [PloW-1:0]         plo_s1_reg;
    logic signed [PhiW-1:0]  phi_s1_reg;
    logic signed [WideW-1:0] off_s1_reg;
    logic signed [TempW-1:0] temp_s1_reg;
    // stage 2
    logic signed [ProdW-1:0] prod_s2_reg;
    logic signed [ProdW-1:0] prod_next;
    logic signed [WideW-1:0] off_s2_reg;
    logic signed [TempW-1:0] temp_s2_reg;
    // stage 3
    logic signed [ProdW-1:0] diff;
    logic signed [ProdW-1:0] p_val;
    logic [PressW-1:0]       press_next;
    logic [PressW-1:0]       press_reg;
    logic signed [TempW-1:0] temp_reg;

    assign vld_src = {vld_reg[NumSt-2:0], mid_valid};

    always_comb
    begin
        adv[NumSt] = result_out.ready;
        for (int k = NumSt - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NumSt; k++)
        begin
            vld_next[k] = adv[k] ? vld_src[k] : vld_reg[k];
        end
    end

    assign mid_ready                    = adv[0];
    assign result_out.valid             = vld_reg[NumSt-1];
    assign result_out.temperature_centi = temp_reg;
    assign result_out.pressure_pascal   = press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // partial products, low part unsigned and high part signed
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            plo_s1_reg  <= PloW'(mid.d1) * PloW'(mid.sens[SplitW-1:0]);
            phi_s1_reg  <= $signed({1'b0, mid.d1}) * $signed(mid.sens[WideW-1:SplitW]);
            off_s1_reg  <= mid.off;
            temp_s1_reg <= mid.temp;
        end
    end

    assign prod_next = (ProdW'(phi_s1_reg) <<< SplitW) + $signed(ProdW'(plo_s1_reg));

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            prod_s2_reg <= prod_next;
            off_s2_reg  <= off_s1_reg;
            temp_s2_reg <= temp_s1_reg;
        end
    end

    always_comb
    begin
        diff       = (prod_s2_reg >>> ShP1) - ProdW'(off_s2_reg);
        p_val      = diff >>> ShP2;
        press_next = p_val[ProdW-1] ? '0 : p_val[PressW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            press_reg <= press_next;
            temp_reg  <= temp_s2_reg;
        end
    end

endmodule

[tb/tb_pressure_temperature_compensation_top.sv]
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation_top
// Self-checking bench for the second-order pressure/temperature compensation.
// ----------------------------------------------------------------------------
// Raw sample beats go in over a valid/ready channel and each accepted beat is
// run through a behavioural copy of the compensation arithmetic, using the
// calibration words last written over APB. Result beats are checked in order,
// field by field. Directed tests cover reset values, the register map, the
// temperature region edges, pressure clamping and extreme calibration words.
// Random tests then cover many calibration sets with random stalls on both
// sides, a stall-free stretch and a long output hold-off that backs up the
// pipeline.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation_top;
    import ptc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [RegIdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [RegIdxW-1:0] REG_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int IDLE_PCT       = 29;

    typedef enum logic [1:0] {REGION_WARM, REGION_COLD, REGION_FRIGID} region_e;

    typedef struct packed {
        logic signed [TempW-1:0] temp;
        logic [PressW-1:0]       press;
    } reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    ptc_in_if  sample_if ();
    ptc_out_if result_if ();

    pressure_temperature_compensation_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_if),
        .result_out (result_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    logic [CoefW-1:0] cal_words [0:5];
    reading_t         pending_readings [$];
    reading_t         oldest_reading;

    int in_idle_pct      = IDLE_PCT;
    int out_idle_pct     = IDLE_PCT;
    int hold_off_request = 0;
    int hold_off_left    = 0;
    int quiet_cycles     = 0;

    int mismatches     = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int cal_sets       = 0;
    int cold_samples   = 0;
    int frigid_samples = 0;
    int clamped_press  = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic reading_t compensate_reading(input logic [RawW-1:0] d1_raw,
                                                    input logic [RawW-1:0] d2_raw,
                                                    output region_e region,
                                                    output bit clamped);
        longint c1, c2, c3, c4, c5, c6;
        longint d1, d2, dt, temp, off, sens, press;
        longint t2, off2, sens2, u, uu, v, vv;
        reading_t r;
        c1 = {48'd0, cal_words[REG_C1]};
        c2 = {48'd0, cal_words[REG_C2]};
        c3 = {48'd0, cal_words[REG_C3]};
        c4 = {48'd0, cal_words[REG_C4]};
        c5 = {48'd0, cal_words[REG_C5]};
        c6 = {48'd0, cal_words[REG_C6]};
        d1 = {40'd0, d1_raw};
        d2 = {40'd0, d2_raw};
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        region = REGION_WARM;
        dt = d2 - (c5 <<< C5Sh);
        temp = longint'(TEMP_REF) + ((dt * c6) >>> ShT);
        off = (c2 <<< ShOffC) + ((c4 * dt) >>> ShOff);
        sens = (c1 <<< ShSensC) + ((c3 * dt) >>> ShSens);
        if (temp < longint'(TEMP_REF))
        begin
            region = REGION_COLD;
            u = temp - longint'(TEMP_REF);
            uu = u * u;
            t2 = (dt * dt) >>> ShT2;
            off2 = (5 * uu) >>> 1;
            sens2 = (5 * uu) >>> 2;
            if (temp < longint'(TEMP_LOW))
            begin
                region = REGION_FRIGID;
                v = temp - longint'(TEMP_LOW);
                vv = v * v;
                off2 = off2 + 7 * vv;
                sens2 = sens2 + ((11 * vv) >>> 1);
            end
        end
        temp = temp - t2;
        off = off - off2;
        sens = sens - sens2;
        press = (((d1 * sens) >>> ShP1) - off) >>> ShP2;
        clamped = (press < 0);
        if (clamped)
            press = 0;
        r.temp = temp[TempW-1:0];
        r.press = press[PressW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx <= REG_C6)
            cal_words[idx] = data[CoefW-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [RegIdxW-1:0] idx, output logic [DataW-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper data bits are noise and must be dropped by the block
    task automatic write_calibration(input cal_t cal);
        apb_write(REG_C1, {16'($urandom), cal.c1});
        apb_write(REG_C2, {16'($urandom), cal.c2});
        apb_write(REG_C3, {16'($urandom), cal.c3});
        apb_write(REG_C4, {16'($urandom), cal.c4});
        apb_write(REG_C5, {16'($urandom), cal.c5});
        apb_write(REG_C6, {16'($urandom), cal.c6});
        cal_sets++;
    endtask

    task automatic send_sample(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
        region_e  region;
        bit       clamped;
        reading_t want;
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(negedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.raw_pressure <= d1;
        sample_if.raw_temperature <= d2;
        do
            @(posedge clk);
        while (!sample_if.ready);
        want = compensate_reading(d1, d2, region, clamped);
        pending_readings.push_back(want);
        samples_sent++;
        if (region != REGION_WARM)
            cold_samples++;
        if (region == REGION_FRIGID)
            frigid_samples++;
        if (clamped)
            clamped_press++;
    endtask

    // mostly temperatures near the reference point, some across the full range
    task automatic send_random_sample();
        logic [RawW-1:0] d1;
        logic [RawW-1:0] d2;
        longint centre;
        longint spread;
        longint shift;
        longint pos;
        if ($urandom_range(4) == 0)
            d1 = RawW'($urandom_range(0, 32'hFFFF));
        else
            d1 = RawW'($urandom_range(0, (1 << RawW) - 1));
        if ($urandom_range(9) < 4)
            d2 = RawW'($urandom_range(0, (1 << RawW) - 1));
        else
        begin
            centre = longint'(cal_words[REG_C5]) <<< C5Sh;
            spread = ($urandom_range(2) == 0) ? (64'sd1 <<< 23) : (64'sd1 <<< 20);
            shift = longint'($urandom_range(0, 32'(spread)));
            if ($urandom_range(1) == 1)
                shift = -shift;
            pos = centre + shift;
            if (pos < 0)
                pos = 0;
            if (pos > (64'sd1 <<< RawW) - 1)
                pos = (64'sd1 <<< RawW) - 1;
            d2 = pos[RawW-1:0];
        end
        send_sample(d1, d2);
    endtask

    function automatic logic [CoefW-1:0] random_coef();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return CoefW'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        wait (pending_readings.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_sample('0, '0);
        send_sample('1, '1);
        drain_results();
    endtask

    task automatic test_register_map();
        cal_t               cal;
        logic [RegIdxW-1:0] idx;
        logic [DataW-1:0]   rd;
        logic [DataW-1:0]   want;
        cal = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
        write_calibration(cal);
        apb_write(REG_SPARE_LO, '1);
        apb_write(REG_SPARE_HI, '1);
        for (int i = 0; i < (1 << RegIdxW); i++)
        begin
            idx = RegIdxW'(i);
            apb_read(idx, rd);
            if (idx <= REG_C6)
                want = DataW'(cal_words[idx]);
            else
                want = '0;
            if (rd !== want)
                report_mismatch($sformatf("register %0d read %0h want %0h", idx, rd, want));
        end
        send_sample(24'd9085466, 24'd8569150);
        send_sample('1, '1);
        drain_results();
    endtask

    // region edges for the calibration left by the register map test
    task automatic test_temperature_regions();
        send_sample(24'd9085466, 24'd8566784);
        send_sample(24'd9085466, 24'd8566783);
        send_sample(24'd9085466, 24'd8000000);
        send_sample(24'd9085466, 24'd7529764);
        send_sample(24'd9085466, 24'd7529763);
        send_sample('1, '0);
        send_sample('0, 24'd8569150);
        drain_results();
    endtask

    task automatic test_calibration_extremes();
        cal_t cal;
        cal = '1;
        write_calibration(cal);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample(24'h800000, 24'h800000);
        drain_results();
        cal = '{c1: '1, c2: '0, c3: '1, c4: '0, c5: '0, c6: '1};
        write_calibration(cal);
        send_sample('1, '1);
        send_sample('1, '0);
        drain_results();
        cal = '{c1: '0, c2: '1, c3: '0, c4: '1, c5: '1, c6: '0};
        write_calibration(cal);
        send_sample('1, '0);
        send_sample('0, '1);
        drain_results();
    endtask

    task automatic test_random_calibrations();
        cal_t cal;
        for (int set_no = 0; set_no < 12; set_no++)
        begin
            cal = '{c1: random_coef(), c2: random_coef(), c3: random_coef(),
                    c4: random_coef(), c5: random_coef(), c6: random_coef()};
            write_calibration(cal);
            for (int n = 0; n < 120; n++)
                send_random_sample();
            drain_results();
        end
    endtask

    task automatic test_streaming();
        in_idle_pct = 0;
        out_idle_pct = 0;
        for (int n = 0; n < 200; n++)
            send_random_sample();
        drain_results();
        in_idle_pct = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    task automatic test_output_hold_off();
        in_idle_pct = 0;
        @(posedge clk);
        hold_off_request = 400;
        for (int n = 0; n < 150; n++)
            send_random_sample();
        drain_results();
        in_idle_pct = IDLE_PCT;
    endtask

    // result sink with random stalls and the requested hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                hold_off_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_off_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_off_left--;
            end
            else
                result_if.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (pending_readings.size() == 0)
                report_mismatch($sformatf("unexpected result temp=%0d press=%0d",
                                          result_if.temperature_centi,
                                          result_if.pressure_pascal));
            else
            begin
                oldest_reading = pending_readings.pop_front();
                if (result_if.temperature_centi !== oldest_reading.temp)
                    report_mismatch($sformatf("temperature_centi got %0d want %0d",
                                              result_if.temperature_centi,
                                              oldest_reading.temp));
                if (result_if.pressure_pascal !== oldest_reading.press)
                    report_mismatch($sformatf("pressure_pascal got %0d want %0d",
                                              result_if.pressure_pascal,
                                              oldest_reading.press));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_readings.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        sample_if.valid = 1'b0;
        sample_if.raw_pressure = '0;
        sample_if.raw_temperature = '0;
        result_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (cal_words[i])
            cal_words[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_map();
        test_temperature_regions();
        test_calibration_extremes();
        test_random_calibrations();
        test_streaming();
        test_output_hold_off();

        wait (pending_readings.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_readings.size()));
        $display("%0d samples and %0d results over %0d calibration sets",
                 samples_sent, results_seen, cal_sets);
        $display("%0d below 20 C, %0d below -15 C, %0d clamped to zero, %0d mismatches",
                 cold_samples, frigid_samples, clamped_press, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
